@@ hw/rtl/kwm_pkg.sv @@
// kwm_pkg: shared types and constants of the k-way merge heap.
// Defines the heap node record (head value plus run index) and field widths.
// No dependencies.
package kwm_pkg;

    localparam int VALUE_W = 32;
    localparam int RUN_W   = 3;
    localparam int ACT_W   = 4;

    localparam logic [ACT_W-1:0] ACT_RESET = 4'd8;

    // One heap entry: a run head and the run it belongs to
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RUN_W-1:0]   run;
    } node_t;

    localparam int NODE_W = $bits(node_t);

endpackage

@@ hw/rtl/kwm_ram.sv @@
// kwm_ram: generic single-write, single-read RAM with registered read data.
// Holds the heap entries of the merge block. No dependencies.
module kwm_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/kwm_cmp.sv @@
// kwm_cmp: the shared key comparator of the merge heap.
// Orders nodes by signed value, then by lower run index. Uses kwm_pkg.
module kwm_cmp
    import kwm_pkg::*;
(
    input  node_t a,
    input  node_t b,
    output logic  a_less
);

    logic [NODE_W-1:0] key_a;
    logic [NODE_W-1:0] key_b;

    // Flip the sign bit so an unsigned compare orders two's complement values
    assign key_a  = {~a.value[VALUE_W-1], a.value[VALUE_W-2:0], a.run};
    assign key_b  = {~b.value[VALUE_W-1], b.value[VALUE_W-2:0], b.run};
    assign a_less = (key_a < key_b);

endmodule

@@ hw/rtl/k_way_merge_heap.sv @@
// k_way_merge_heap: top level of the k-way merge of sorted runs.
// Sequencer and heap control around kwm_ram (heap entries) and kwm_cmp
// (shared compare unit). Uses kwm_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall, fields run, value, exhausted) delivers
//   run heads. The first active_runs transfers prime the heap; each later
//   transfer replaces the head of the run named by the last result's
//   source_run (run is then ignored). Output channel (out_valid/out_stall,
//   fields out_value, source_run, last) carries the merged ascending stream.
//   Write active_runs (cfg_wr_en/cfg_wr_data) only while idle; not enforced.
// Timing:
//   in_stall is high while an item is being processed; the shared comparator
//   and the single RAM read port serve every heap level in turn.
//   Priming insert: each parent is read, then compared with the new head,
//   which climbs past a larger parent and is written where it settles. A
//   priming item that inserts nothing does no sift-up. Merge step: per
//   node, the left child is read, then the right child; the smaller child
//   is kept (the left one when there is no right child) and compared with
//   the moving entry, which is written where it settles. When a run ends,
//   the last entry is fetched first. An item that emits then loads the
//   output register; out_valid rises as in_stall falls.
// Reset: heap empty, no heads held, active_runs = 8, output empty.
// Stall: the result sits in an output register; the next item is accepted
//   and sifted meanwhile, and the block waits only when it has a second
//   result to emit before the first one has transferred.
module k_way_merge_heap
    import kwm_pkg::*;
#(
    parameter int RUNS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [ACT_W-1:0]          cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [RUN_W-1:0]          run,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      exhausted,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [VALUE_W-1:0] out_value,
    output logic [RUN_W-1:0]          source_run,
    output logic                      last
);

    localparam int IW = $clog2(RUNS);
    localparam int CW = $clog2(RUNS + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_RDLAST = 4'd1;
    localparam logic [3:0] ST_SD_RL  = 4'd2;
    localparam logic [3:0] ST_SD_RR  = 4'd3;
    localparam logic [3:0] ST_SD_CR  = 4'd4;
    localparam logic [3:0] ST_SD_CM  = 4'd5;
    localparam logic [3:0] ST_SU_CHK = 4'd6;
    localparam logic [3:0] ST_SU_CM  = 4'd7;
    localparam logic [3:0] ST_EMIT   = 4'd8;

    logic [3:0]          state_reg, state_next;
    node_t               node_reg, node_next;
    node_t               child_reg, child_next;
    logic [IW-1:0]       child_idx_reg, child_idx_next;
    logic [IW-1:0]       hole_reg, hole_next;
    node_t               root_reg, root_next;
    logic [CW-1:0]       heap_count_reg, heap_count_next;
    logic [CW-1:0]       primed_count_reg, primed_count_next;
    logic [RUNS-1:0]     head_valid_reg, head_valid_next;
    logic                emit_pend_reg, emit_pend_next;
    logic [ACT_W-1:0]    active_runs_reg;
    logic                out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]  out_value_reg, out_value_next;
    logic [RUN_W-1:0]    source_run_reg, source_run_next;
    logic                last_reg, last_next;

    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    node_t               ram_wdata;
    logic [IW-1:0]       ram_raddr;
    node_t               ram_rdata;

    node_t               cmp_a;
    node_t               cmp_b;
    logic                cmp_less;

    logic [CW-1:0]       eff_runs;
    logic                in_fire;
    logic [CW-1:0]       primed_inc;
    logic [IW:0]         left_idx;
    logic [IW:0]         right_idx;
    logic [IW:0]         count_ext;
    logic [IW-1:0]       parent_idx;
    logic [IW-1:0]       run_idx;
    logic [IW-1:0]       root_idx;

    kwm_ram #(
        .WIDTH (NODE_W),
        .DEPTH (RUNS)
    ) u_heap_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kwm_cmp u_cmp (
        .a      (cmp_a),
        .b      (cmp_b),
        .a_less (cmp_less)
    );

    // Clamp the configured run count into 1..RUNS
    always_comb
    begin
        if (active_runs_reg == '0)
        begin
            eff_runs = CW'(1);
        end
        else if (32'(active_runs_reg) > 32'(RUNS))
        begin
            eff_runs = CW'(RUNS);
        end
        else
        begin
            eff_runs = CW'(active_runs_reg);
        end
    end

    // Heap index arithmetic
    assign in_stall   = (state_reg != ST_IDLE);
    assign in_fire    = in_valid && !in_stall;
    assign primed_inc = primed_count_reg + 1'b1;
    assign left_idx   = {hole_reg, 1'b1};
    assign right_idx  = left_idx + 1'b1;
    assign count_ext  = (IW + 1)'(heap_count_reg);
    assign parent_idx = (hole_reg - 1'b1) >> 1;
    assign run_idx    = IW'(run);
    assign root_idx   = IW'(root_reg.run);

    // Route the shared comparator by sequencer step
    always_comb
    begin
        cmp_a = node_reg;
        cmp_b = ram_rdata;
        case (state_reg)
            ST_SD_CR:
            begin
                cmp_a = ram_rdata;
                cmp_b = child_reg;
            end
            ST_SD_CM:
            begin
                cmp_a = child_reg;
                cmp_b = node_reg;
            end
            default:
            begin
                cmp_a = node_reg;
                cmp_b = ram_rdata;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        node_next         = node_reg;
        child_next        = child_reg;
        child_idx_next    = child_idx_reg;
        hole_next         = hole_reg;
        heap_count_next   = heap_count_reg;
        primed_count_next = primed_count_reg;
        head_valid_next   = head_valid_reg;
        emit_pend_next    = emit_pend_reg;
        ram_we            = 1'b0;
        ram_waddr         = hole_reg;
        ram_wdata         = node_reg;
        ram_raddr         = IW'(heap_count_reg - 1'b1);
        out_valid_next    = out_valid_reg && out_stall;
        out_value_next    = out_value_reg;
        source_run_next   = source_run_reg;
        last_next         = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (primed_count_reg < eff_runs)
                    begin
                        // Priming: insert the first head of a run
                        if (32'(run) < 32'(RUNS))
                        begin
                            primed_count_next = primed_inc;
                            emit_pend_next    = (primed_inc == eff_runs);
                            if (!exhausted && !head_valid_reg[run_idx] &&
                                (32'(heap_count_reg) < 32'(RUNS)))
                            begin
                                head_valid_next[run_idx] = 1'b1;
                                node_next       = '{value: value, run: run};
                                hole_next       = IW'(heap_count_reg);
                                heap_count_next = heap_count_reg + 1'b1;
                                state_next      = ST_SU_CHK;
                            end
                            else if (primed_inc == eff_runs)
                            begin
                                if (heap_count_reg == '0)
                                begin
                                    head_valid_next   = '0;
                                    heap_count_next   = '0;
                                    primed_count_next = '0;
                                end
                                else
                                begin
                                    state_next = ST_EMIT;
                                end
                            end
                        end
                    end
                    else if (heap_count_reg == '0)
                    begin
                        head_valid_next   = '0;
                        primed_count_next = '0;
                    end
                    else if (exhausted)
                    begin
                        // Drop the root run; the last entry moves to the root
                        head_valid_next[root_idx] = 1'b0;
                        heap_count_next = heap_count_reg - 1'b1;
                        if (heap_count_reg == CW'(1))
                        begin
                            head_valid_next   = '0;
                            primed_count_next = '0;
                        end
                        else
                        begin
                            emit_pend_next = 1'b1;
                            state_next     = ST_RDLAST;
                        end
                    end
                    else
                    begin
                        // Replace the root head and sift it down
                        node_next      = '{value: value, run: root_reg.run};
                        hole_next      = '0;
                        emit_pend_next = 1'b1;
                        state_next     = ST_SD_RL;
                    end
                end
            end

            ST_RDLAST:
            begin
                node_next  = ram_rdata;
                hole_next  = '0;
                state_next = ST_SD_RL;
            end

            ST_SD_RL:
            begin
                if (left_idx >= count_ext)
                begin
                    ram_we     = 1'b1;
                    state_next = emit_pend_reg ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    ram_raddr  = IW'(left_idx);
                    state_next = ST_SD_RR;
                end
            end

            ST_SD_RR:
            begin
                child_next     = ram_rdata;
                child_idx_next = IW'(left_idx);
                ram_raddr      = IW'(right_idx);
                state_next     = (right_idx < count_ext) ? ST_SD_CR : ST_SD_CM;
            end

            ST_SD_CR:
            begin
                // Keep the smaller of the two children
                if (cmp_less)
                begin
                    child_next     = ram_rdata;
                    child_idx_next = IW'(right_idx);
                end
                state_next = ST_SD_CM;
            end

            ST_SD_CM:
            begin
                ram_we = 1'b1;
                if (cmp_less)
                begin
                    ram_wdata  = child_reg;
                    hole_next  = child_idx_reg;
                    state_next = ST_SD_RL;
                end
                else
                begin
                    state_next = emit_pend_reg ? ST_EMIT : ST_IDLE;
                end
            end

            ST_SU_CHK:
            begin
                if (hole_reg == '0)
                begin
                    ram_we     = 1'b1;
                    state_next = emit_pend_reg ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    ram_raddr  = parent_idx;
                    state_next = ST_SU_CM;
                end
            end

            ST_SU_CM:
            begin
                ram_we = 1'b1;
                if (cmp_less)
                begin
                    // Move the parent down and climb
                    ram_wdata  = ram_rdata;
                    hole_next  = parent_idx;
                    state_next = ST_SU_CHK;
                end
                else
                begin
                    state_next = emit_pend_reg ? ST_EMIT : ST_IDLE;
                end
            end

            ST_EMIT:
            begin
                // Load the root into the output register once it is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = root_reg.value;
                    source_run_next = root_reg.run;
                    last_next       = (heap_count_reg == CW'(1));
                    emit_pend_next  = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Shadow the root entry on every write to the top of the heap
    always_comb
    begin
        root_next = root_reg;
        if (ram_we && (ram_waddr == '0))
        begin
            root_next = ram_wdata;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            heap_count_reg   <= '0;
            primed_count_reg <= '0;
            head_valid_reg   <= '0;
            emit_pend_reg    <= 1'b0;
            active_runs_reg  <= ACT_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            heap_count_reg   <= heap_count_next;
            primed_count_reg <= primed_count_next;
            head_valid_reg   <= head_valid_next;
            emit_pend_reg    <= emit_pend_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_wr_en)
            begin
                active_runs_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        node_reg       <= node_next;
        child_reg      <= child_next;
        child_idx_reg  <= child_idx_next;
        hole_reg       <= hole_next;
        root_reg       <= root_next;
        out_value_reg  <= out_value_next;
        source_run_reg <= source_run_next;
        last_reg       <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign source_run = source_run_reg;
    assign last       = last_reg;

endmodule
